// File: rtl/core/tfc_pkg.sv
package tfc_pkg;

  // Shortest frame that can pass: header, length field, 16 payload bytes, checksum.
  localparam int unsigned MIN_FRAME_BYTES = 21;

  // Byte positions inside a frame.
  localparam logic [7:0] POS_MAGIC     = 8'd0;
  localparam logic [7:0] POS_TYPE      = 8'd1;
  localparam logic [7:0] POS_LEN_LO    = 8'd2;
  localparam logic [7:0] POS_LEN_HI    = 8'd3;
  localparam logic [7:0] POS_PAY_FIRST = 8'd4;
  localparam logic [7:0] POS_PAY_LAST  = 8'd19;
  localparam logic [7:0] COUNT_MAX     = 8'd255;

  // Configuration register indexes.
  localparam logic [1:0] REG_MAGIC     = 2'd0;
  localparam logic [1:0] REG_DATA_TYPE = 2'd1;
  localparam logic [1:0] REG_PAY_LEN   = 2'd2;

  // Result codes, in check priority order.
  typedef enum logic [2:0] {
    FAIL_OK        = 3'd0,
    FAIL_TOO_SHORT = 3'd1,
    FAIL_MAGIC     = 3'd2,
    FAIL_TYPE      = 3'd3,
    FAIL_LENGTH    = 3'd4,
    FAIL_CHECKSUM  = 3'd5
  } fail_code_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic        frame_ok;
    logic [2:0]  fail_code;
    logic [31:0] temperature_word;
    logic [31:0] setpoint_word;
    logic [31:0] deviation_word;
    logic [31:0] drive_word;
  } out_item_t;

  // Header error flags and running frame status handed to the verdict logic.
  typedef struct packed {
    logic       magic_wrong;
    logic       type_wrong;
    logic       len_wrong;
    logic [7:0] count;
    logic [7:0] xor_sum;
  } frame_status_t;

endpackage

// File: rtl/core/tfc_verdict.sv
module tfc_verdict
  import tfc_pkg::*;
(
  input  frame_status_t         status,
  input  logic [3:0][31:0]      payload,
  output out_item_t             result
);

  fail_code_t code;

  // The first failing check decides the code.
  always_comb begin
    priority if (status.count < 8'(MIN_FRAME_BYTES)) begin
      code = FAIL_TOO_SHORT;
    end else if (status.magic_wrong) begin
      code = FAIL_MAGIC;
    end else if (status.type_wrong) begin
      code = FAIL_TYPE;
    end else if (status.len_wrong) begin
      code = FAIL_LENGTH;
    end else if (status.xor_sum != 8'd0) begin
      code = FAIL_CHECKSUM;
    end else begin
      code = FAIL_OK;
    end
  end

  // Payload words are shown only for a frame that passed.
  always_comb begin
    result.frame_ok         = (code == FAIL_OK);
    result.fail_code        = code;
    result.temperature_word = (code == FAIL_OK) ? payload[0] : 32'd0;
    result.setpoint_word    = (code == FAIL_OK) ? payload[1] : 32'd0;
    result.deviation_word   = (code == FAIL_OK) ? payload[2] : 32'd0;
    result.drive_word       = (code == FAIL_OK) ? payload[3] : 32'd0;
  end

endmodule

// File: rtl/core/telemetry_frame_checker.sv
// The result is registered: it is valid in the cycle after the transfer of a frame's last byte.
// Throughput: one byte per cycle; the result register is loaded while the
// previous result leaves, so input stalls only while a result waits unread.
// Reset (rst_n low, synchronous): frame state, result valid and the
// configuration registers return to their defaults (magic 0, type 1, length 16).
module telemetry_frame_checker
  import tfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [7:0]       magic_value_r;
  logic [7:0]       data_type_r;
  logic [15:0]      pay_len_r;

  logic [7:0]       count_r, count_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic             magic_wrong_r, magic_wrong_nxt;
  logic             type_wrong_r, type_wrong_nxt;
  logic             len_wrong_r, len_wrong_nxt;
  logic [7:0]       len_lo_r, len_lo_nxt;
  logic [3:0][31:0] payload_r;
  logic [3:0]       pay_off;

  logic             out_valid_r;
  out_item_t        out_data_r;
  out_item_t        verdict;
  frame_status_t    status;
  logic             in_xfer;
  logic             out_xfer;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign in_stall = out_valid_r && out_stall;

  // Configuration writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_value_r <= 8'd0;
      data_type_r   <= 8'd1;
      pay_len_r     <= 16'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAGIC:     magic_value_r <= cfg_wdata[7:0];
        REG_DATA_TYPE: data_type_r   <= cfg_wdata[7:0];
        REG_PAY_LEN:   pay_len_r     <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  // Header checks, running checksum and saturating byte count for this byte.
  always_comb begin
    magic_wrong_nxt = magic_wrong_r;
    type_wrong_nxt  = type_wrong_r;
    len_wrong_nxt   = len_wrong_r;
    len_lo_nxt      = len_lo_r;
    unique case (count_r)
      POS_MAGIC:  magic_wrong_nxt = (in_data.rx_byte != magic_value_r);
      POS_TYPE:   type_wrong_nxt  = (in_data.rx_byte != data_type_r);
      POS_LEN_LO: len_lo_nxt      = in_data.rx_byte;
      POS_LEN_HI: len_wrong_nxt   = ({in_data.rx_byte, len_lo_r} != pay_len_r);
      default:    ;
    endcase
    xor_nxt   = xor_r ^ in_data.rx_byte;
    count_nxt = (count_r == COUNT_MAX) ? COUNT_MAX : count_r + 8'd1;
    pay_off   = count_r[3:0] - POS_PAY_FIRST[3:0];
  end

  // Status of the frame: header flags as registered before the current byte, count and checksum with it.
  assign status.magic_wrong = magic_wrong_r;
  assign status.type_wrong  = type_wrong_r;
  assign status.len_wrong   = len_wrong_r;
  assign status.count       = count_nxt;
  assign status.xor_sum     = xor_nxt;

  tfc_verdict u_verdict (
    .status  (status),
    .payload (payload_r),
    .result  (verdict)
  );

  // Frame state: updated on every byte transfer, cleared after the last byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r       <= 8'd0;
      xor_r         <= 8'd0;
      magic_wrong_r <= 1'b0;
      type_wrong_r  <= 1'b0;
      len_wrong_r   <= 1'b0;
      len_lo_r      <= 8'd0;
    end else if (in_xfer) begin
      if (in_data.frame_end) begin
        count_r       <= 8'd0;
        xor_r         <= 8'd0;
        magic_wrong_r <= 1'b0;
        type_wrong_r  <= 1'b0;
        len_wrong_r   <= 1'b0;
        len_lo_r      <= 8'd0;
      end else begin
        count_r       <= count_nxt;
        xor_r         <= xor_nxt;
        magic_wrong_r <= magic_wrong_nxt;
        type_wrong_r  <= type_wrong_nxt;
        len_wrong_r   <= len_wrong_nxt;
        len_lo_r      <= len_lo_nxt;
      end
    end
  end

  // Payload bytes land in their little-endian lane of the word store.
  always_ff @(posedge clk) begin
    if (in_xfer && count_r >= POS_PAY_FIRST && count_r <= POS_PAY_LAST) begin
      payload_r[pay_off[3:2]][{pay_off[1:0], 3'b000} +: 8] <= in_data.rx_byte;
    end
  end

  // Result register: loaded by the last byte, emptied by an output transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer && in_data.frame_end) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_data.frame_end) begin
      out_data_r <= verdict;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/tfc_checker.sv
module tfc_checker
  import tfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A new result follows only the transfer of a frame's last byte.
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_data.frame_end))
    else $error("result without a final byte");

  // Input is never stalled while the result register is empty.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  // A pass carries code zero; a failure carries a nonzero code.
  a_ok_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.frame_ok == (out_data.fail_code == FAIL_OK)))
    else $error("frame_ok disagrees with fail_code");

  // A failed frame shows no payload.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.frame_ok |->
      out_data.temperature_word == 32'd0 && out_data.setpoint_word == 32'd0 &&
      out_data.deviation_word == 32'd0 && out_data.drive_word == 32'd0)
    else $error("payload shown on a failed frame");

endmodule

bind telemetry_frame_checker tfc_checker u_tfc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
